/* rtl/itd_pkg.sv */
// Shared types, constants and the digit-to-character function of the
// integer-to-radix-digits block. No dependencies.
`default_nettype none

package itd_pkg;

	// Field widths fixed by the interface.
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// Quotient bits produced by the divider in one cycle.
	localparam int STEP_BITS = 8;

	// Base limits; radix values outside them saturate.
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// Character mapping constants.
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
	localparam logic [CHAR_W-1:0]  ASCII_NINE = 7'h39;
	localparam logic [CHAR_W-1:0]  ASCII_F    = 7'h46;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a new value and radix
		logic step;       // one divider step
		logic step_last;  // final divider cycle of a digit: push the remainder
		logic pop;        // move the top digit into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic quot_zero;   // quotient after this divider cycle is zero
		logic last_entry;  // exactly one digit left on the stack
		logic out_free;    // output register can take a digit this cycle
	} sts_t;

	// Map a digit value to its ASCII character, letters above nine.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		if (d < DEC_DIGITS) begin
			return ASCII_ZERO + CHAR_W'(d);
		end
		return ASCII_A + CHAR_W'(d - DEC_DIGITS);
	endfunction

endpackage

`default_nettype wire

/* rtl/itd_ctrl.sv */
// Controller of the integer-to-radix-digits block: sequences load, division
// and emission. Depends on itd_pkg.
`default_nettype none

module itd_ctrl #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire itd_pkg::sts_t sts,
	output itd_pkg::cmd_t      cmd
);

	localparam int CHUNKS = (VALUE_BITS + itd_pkg::STEP_BITS - 1) / itd_pkg::STEP_BITS;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   chunk_q;
	logic            ready_q;

	assign s_tready = ready_q;

	// Commands follow the state and the current status.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
			end
			ST_DIV: begin
				cmd.step      = 1'b1;
				cmd.step_last = (chunk_q == CW'(CHUNKS - 1));
			end
			ST_EMIT: begin
				cmd.pop = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State, chunk counter and the registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
						chunk_q <= '0;
						ready_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (chunk_q == CW'(CHUNKS - 1)) begin
						chunk_q <= '0;
						if (sts.quot_zero) begin
							state_q <= ST_EMIT;
						end
					end else begin
						chunk_q <= chunk_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (sts.out_free && sts.last_entry) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/itd_datapath.sv */
// Datapath of the integer-to-radix-digits block: radix divider, digit stack
// and output register. Depends on itd_pkg.
`default_nettype none

module itd_datapath #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire itd_pkg::cmd_t                cmd,
	output itd_pkg::sts_t                     sts,
	input  wire logic [VALUE_BITS-1:0]        value_in,
	input  wire logic [itd_pkg::RADIX_W-1:0]  radix_in,
	input  wire logic                         m_tready,
	output logic                              m_tvalid,
	output logic [itd_pkg::CHAR_W-1:0]        digit_char,
	output logic                              last_digit
);

	localparam int SB     = itd_pkg::STEP_BITS;
	localparam int CHUNKS = (VALUE_BITS + SB - 1) / SB;
	localparam int W      = CHUNKS * SB;
	localparam int DW     = $clog2(VALUE_BITS + 1);
	localparam int RW     = itd_pkg::RADIX_W;
	localparam int GW     = itd_pkg::DIGIT_W;

	logic [W-1:0]    w_q;
	logic [RW-1:0]   radix_q;
	logic [GW-1:0]   rem_q;
	logic [GW-1:0]   stk_q [VALUE_BITS];
	logic [DW-1:0]   depth_q;
	logic            valid_q;
	logic [itd_pkg::CHAR_W-1:0] char_q;
	logic            last_q;

	logic [W-1:0]    w_next;
	logic [GW-1:0]   rem_next;
	logic [SB-1:0]   qbits;
	logic [RW-1:0]   radix_sat;

	// Saturate the incoming radix to the supported range.
	always_comb begin
		if (radix_in < itd_pkg::RADIX_MIN) begin
			radix_sat = itd_pkg::RADIX_MIN;
		end else if (radix_in > itd_pkg::RADIX_MAX) begin
			radix_sat = itd_pkg::RADIX_MAX;
		end else begin
			radix_sat = radix_in;
		end
	end

	// Eight restoring division steps on the top byte of the working word.
	always_comb begin
		logic [RW-1:0] t;
		logic [GW-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < SB; i++) begin
			t = {r, w_q[W-1-i]};
			if (t >= radix_q) begin
				qbits[SB-1-i] = 1'b1;
				r = GW'(t - radix_q);
			end else begin
				r = t[GW-1:0];
			end
		end
		rem_next = r;
		w_next   = (w_q << SB) | W'(qbits);
	end

	assign sts.quot_zero  = (w_next == '0);
	assign sts.last_entry = (depth_q == DW'(1));
	assign sts.out_free   = !valid_q || m_tready;

	// Working word, radix and partial remainder.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q     <= W'(value_in);
			radix_q <= radix_sat;
			rem_q   <= '0;
		end else if (cmd.step) begin
			w_q   <= w_next;
			rem_q <= cmd.step_last ? '0 : rem_next;
		end
	end

	// Digit stack: pushes enter at the top, pops leave from the top.
	always_ff @(posedge clk) begin
		if (cmd.step_last) begin
			stk_q[0] <= rem_next;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	// Stack depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.step_last) begin
			depth_q <= depth_q + DW'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_q - DW'(1);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			char_q <= itd_pkg::digit_to_ascii(stk_q[0]);
			last_q <= (depth_q == DW'(1));
		end
	end

	assign m_tvalid   = valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	// A pop always finds a digit on the stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (depth_q != '0))
		else $error("digit popped from an empty stack");

	// A new value is only taken once the digit stack is empty.
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (depth_q == '0))
		else $error("value loaded while digits remain");

	// A pop never overwrites a digit that waits in the output register.
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (!valid_q || m_tready))
		else $error("output register overwritten");

	// Every emitted character is a decimal digit or a letter A to F.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((char_q >= itd_pkg::ASCII_ZERO && char_q <= itd_pkg::ASCII_NINE) ||
			(char_q >= itd_pkg::ASCII_A && char_q <= itd_pkg::ASCII_F)))
		else $error("character out of range");

endmodule

`default_nettype wire

/* rtl/integer_to_radix_digits.sv */
// Top level of the integer-to-radix-digits block: joins controller and
// datapath. Depends on itd_pkg, itd_ctrl and itd_datapath.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    s_tdata: value, radix
// m_       out  m_tvalid/m_tready    m_tdata: digit_char; m_tlast: last_digit
//
// The divider resolves eight quotient bits per cycle and divides the whole
// working word once for each digit; digits are pushed onto the digit stack
// least significant first and drained from it most significant first.
// A new item is taken once the last digit has entered the output register.
// Reset empties the digit stack and the output register; m_tready low only
// holds the output register and pauses the drain.
`default_nettype none

module integer_to_radix_digits #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// Fields from bit 0: value [VALUE_BITS-1:0], radix [VALUE_BITS+4:VALUE_BITS].
	input  wire logic [((VALUE_BITS + itd_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_tdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// Fields from bit 0: digit_char [6:0], zero fill [7].
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tvalid,
	input  wire logic  m_tready
);

	itd_pkg::cmd_t cmd;
	itd_pkg::sts_t sts;
	logic [itd_pkg::CHAR_W-1:0] digit_char;

	itd_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itd_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value_in   (s_tdata[VALUE_BITS-1:0]),
		.radix_in   (s_tdata[VALUE_BITS+itd_pkg::RADIX_W-1:VALUE_BITS]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.digit_char (digit_char),
		.last_digit (m_tlast)
	);

	assign m_tdata = {1'b0, digit_char};

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for integer_to_radix_digits: a digit predictor feeds a
// scoreboard that checks every transfer on the output stream.
// Depends on itd_pkg and the integer_to_radix_digits RTL.
`timescale 1ns / 100ps

module tb;

	localparam int VALUE_BITS = 31;
	localparam int IN_W = ((VALUE_BITS + itd_pkg::RADIX_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 440;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 600;
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_LETTER_A = 7'h41;

	// Gap patterns for either side of the stream.
	typedef enum int {
		GAP_NONE,
		GAP_FULL,
		GAP_SPARSE
	} gap_mode_t;

	typedef struct {
		logic [6:0] ch;
		logic       last;
		int         item;
	} digit_exp_t;

	// Scoreboard: predicts the digit string of each accepted item and checks
	// the output transfers in order.
	class digit_scoreboard;
		digit_exp_t digits_due[$];
		int errors;
		int items_seen;

		function new();
			errors = 0;
			items_seen = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return digits_due.size();
		endfunction

		// Work out the digits of one accepted item, most significant first.
		function void note_input(input logic [30:0] value, input logic [4:0] radix);
			logic [30:0] rest;
			int unsigned base;
			logic [3:0] lsd_first[$];
			digit_exp_t e;
			rest = value;
			base = radix;
			if (base < 2) base = 2;
			if (base > 16) base = 16;
			if (rest == 0) begin
				lsd_first.push_back(4'd0);
			end
			while (rest != 0) begin
				lsd_first.push_back(4'(rest % base));
				rest = 31'(rest / base);
			end
			for (int k = lsd_first.size() - 1; k >= 0; k--) begin
				if (lsd_first[k] < 4'd10) begin
					e.ch = CHAR_ZERO + 7'(lsd_first[k]);
				end else begin
					e.ch = CHAR_LETTER_A + 7'(lsd_first[k] - 4'd10);
				end
				e.last = (k == 0);
				e.item = items_seen;
				digits_due.push_back(e);
			end
			items_seen++;
		endfunction

		// Compare one output transfer with the oldest expected digit.
		task check_result(input logic [7:0] data, input logic last);
			digit_exp_t e;
			if (digits_due.size() == 0) begin
				report($sformatf("unexpected digit 0x%02h last=%0b", data, last));
			end else begin
				e = digits_due.pop_front();
				if (data !== {1'b0, e.ch}) begin
					report($sformatf("item %0d: digit 0x%02h, want 0x%02h",
						e.item, data, {1'b0, e.ch}));
				end
				if (last !== e.last) begin
					report($sformatf("item %0d: last %0b, want %0b", e.item, last, e.last));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic [IN_W-1:0] s_tdata;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tvalid;
	logic m_tready;

	digit_scoreboard sb;
	gap_mode_t send_mode;
	gap_mode_t recv_mode;
	int hold_request;

	integer_to_radix_digits #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	// 20 ns clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int draw_gap(input gap_mode_t mode);
		case (mode)
			GAP_NONE: return 0;
			GAP_FULL: return $urandom_range(0, 19);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	// Offer one item after a random gap and wait for its transfer.
	task automatic send_item(input logic [30:0] value, input logic [4:0] radix);
		logic [IN_W-1:0] word;
		int gap;
		word = '0;
		word[30:0] = value;
		word[35:31] = radix;
		gap = draw_gap(send_mode);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata = word;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(value, radix);
	endtask

	// Hold the input side idle until every predicted digit has come out.
	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: stalls a random number of cycles before each transfer, or
	// for a long stretch when one is requested.
	task automatic run_receiver();
		int n;
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
			end else begin
				n = draw_gap(recv_mode);
			end
			@(negedge clk);
			if (n > 0) begin
				m_tready = 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	endtask

	function automatic logic [4:0] pick_radix();
		if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
		return 5'($urandom_range(2, 16));
	endfunction

	// Mix of full-range, small, zero, maximum and power-of-base values.
	function automatic logic [30:0] pick_value(input logic [4:0] radix);
		longint p;
		int unsigned base;
		int k;
		base = radix;
		if (base < 2) base = 2;
		if (base > 16) base = 16;
		case ($urandom_range(0, 7))
			0: return 31'($urandom_range(0, 255));
			1: return '0;
			2: return VALUE_MAX;
			3: begin
				p = 1;
				k = $urandom_range(1, 30);
				repeat (k) begin
					if (p * base <= longint'(VALUE_MAX)) p = p * base;
				end
				return 31'(p - longint'($urandom_range(0, 1)));
			end
			default: return 31'($urandom());
		endcase
	endfunction

	// Output checking on every accepted transfer.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tlast);
		end
	end

	// Run limit, far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		logic [4:0] r;
		sb = new();
		arst_n = 1'b0;
		s_tdata = '0;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		send_mode = GAP_NONE;
		recv_mode = GAP_NONE;
		hold_request = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		fork
			run_receiver();
		join_none

		// Directed items: zero, extremes, letters under base 16, saturation.
		send_item('0, 5'd10);
		send_item('0, 5'd2);
		send_item(VALUE_MAX, 5'd2);
		send_item(VALUE_MAX, 5'd16);
		send_item(VALUE_MAX, 5'd10);
		send_item(VALUE_MAX, 5'd3);
		send_item(31'd1, 5'd2);
		send_item(31'd15, 5'd16);
		send_item(31'd255, 5'd16);
		send_item(31'd10, 5'd11);
		send_item(31'd12, 5'd13);
		send_item(31'd14, 5'd15);
		send_item(31'd9, 5'd10);
		send_item(31'h4000_0000, 5'd2);
		send_item(31'd1234567, 5'd0);
		send_item(31'd1234567, 5'd1);
		send_item(31'd1234567, 5'd17);
		send_item(31'd1234567, 5'd31);
		send_item('0, 5'd31);
		send_item(31'h2AAA_AAAA, 5'd7);
		send_item(31'h5555_5555, 5'd12);
		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();

		// Random items with changing gap patterns on both sides.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				send_mode = gap_mode_t'($urandom_range(0, 2));
				recv_mode = gap_mode_t'($urandom_range(0, 2));
			end
			// Long receiver stall while the input keeps offering items.
			if (i == 100) begin
				send_mode = GAP_NONE;
				hold_request = HOLD_CYCLES;
			end
			// Input pause until the output has caught up.
			if (i == 250) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				wait_drained();
			end
			r = pick_radix();
			send_item(pick_value(r), r);
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d expected digits never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* integer_to_radix_digits.f */
rtl/itd_pkg.sv
rtl/itd_ctrl.sv
rtl/itd_datapath.sv
rtl/integer_to_radix_digits.sv
tb/sv/tb.sv
